### hdl/trlc_pkg.sv
package trlc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned DistW    = 15;
  localparam int unsigned VolW     = 10;
  localparam int unsigned AccW     = 20;
  localparam int unsigned CntW     = 16;
  localparam int unsigned SumW     = 36;

  localparam logic [CfgIdxW-1:0] RegEmptyDepth = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLevelSpan  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRefillDist = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFullVolume = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDeadband   = 3'd4;

  localparam logic [1:0] CmdEcho   = 2'd0;
  localparam logic [1:0] CmdButton = 2'd1;
  localparam logic [1:0] CmdRemote = 2'd2;

  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef enum logic [2:0] {
    StIdle,
    StVolDiv,
    StUpdate,
    StAvgRefill,
    StAvgEvap,
    StOut
  } trlc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic vol_start;
    logic update;
    logic avg_start;
    logic avg_sel;
    logic out_load;
  } trlc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic is_echo;
  } trlc_status_t;

endpackage

### hdl/trlc_divider.sv
module trlc_divider import trlc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SumW-1:0] dividend_i,
  input  logic [CntW-1:0] divisor_i,
  output logic            busy_o,
  output logic [SumW-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0]  quo_q, quo_d;
  logic [CntW:0]    rem_q, rem_d;
  logic [CntW-1:0]  dvs_q;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [CntW:0]    trial;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[CntW-1:0], quo_q[SumW-1]};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = StepW'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

### hdl/trlc_datapath.sv
module trlc_datapath import trlc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trlc_cmd_t          cmd_i,
  output trlc_status_t       status_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [1:0]         command_i,
  input  logic [15:0]        echo_time_i,
  input  logic               button_level_i,
  input  logic               remote_on_i,
  output logic               pump_on_o,
  output logic [VolW-1:0]    volume_milli_o,
  output logic [AccW-1:0]    refill_total_o,
  output logic [AccW-1:0]    evaporation_total_o,
  output logic [CntW-1:0]    refill_cycles_o,
  output logic [CntW-1:0]    evaporation_cycles_o,
  output logic [AccW-1:0]    refill_average_o,
  output logic [AccW-1:0]    evaporation_average_o,
  output logic               full_stop_o
);

  // Configuration registers.
  logic [DistW-1:0] empty_q, span_q, rdist_q;
  logic [VolW-1:0]  full_q, dband_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 15'd1500;
      span_q  <= 15'd1300;
      rdist_q <= 15'd1000;
      full_q  <= 10'd980;
      dband_q <= 10'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegEmptyDepth: empty_q <= cfg_data_i;
        RegLevelSpan:  span_q  <= cfg_data_i;
        RegRefillDist: rdist_q <= cfg_data_i;
        RegFullVolume: full_q  <= cfg_data_i[VolW-1:0];
        RegDeadband:   dband_q <= cfg_data_i[VolW-1:0];
        default: ;
      endcase
    end
  end

  // Captured beat, with the distance worked out on the way in.
  logic [1:0]  cmd_q;
  logic        btn_q, rem_q;
  logic [16:0] dist_q;
  logic [20:0] echo17;
  logic [41:0] dist_prod;

  // Distance is echo*17/10; the divide by ten is a multiply by 2^24/10, rounded up,
  // which is exact over the whole echo range.
  assign echo17    = {5'd0, echo_time_i} * 21'd17;
  assign dist_prod = {21'd0, echo17} * 42'd1677722;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= command_i;
      btn_q  <= button_level_i;
      rem_q  <= remote_on_i;
      dist_q <= dist_prod[40:24];
    end
  end

  // Clamped depth and the volume dividend.
  logic [DistW-1:0] span_eff, depth;
  logic [24:0]      depth_k;
  assign span_eff = (span_q == '0) ? DistW'(1) : span_q;
  always_comb begin
    if ({2'b0, empty_q} > dist_q) depth = DistW'({2'b0, empty_q} - dist_q);
    else depth = '0;
    if (depth > span_eff) depth = span_eff;
  end
  assign depth_k = {10'd0, depth} * 25'd1000;

  // Shared serial divider.
  logic            dv_start, dv_busy;
  logic [SumW-1:0] dv_dividend, dv_quot;
  logic [CntW-1:0] dv_divisor;
  logic [SumW-1:0] rsum_q, esum_q;
  logic [CntW-1:0] rcnt_q, ecnt_q;

  always_comb begin
    dv_start    = cmd_i.vol_start | cmd_i.avg_start;
    dv_dividend = SumW'(depth_k);
    dv_divisor  = CntW'(span_eff);
    if (cmd_i.avg_start) begin
      dv_dividend = cmd_i.avg_sel ? esum_q : rsum_q;
      dv_divisor  = cmd_i.avg_sel ? ecnt_q : rcnt_q;
    end
  end

  trlc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_dividend),
    .divisor_i  (dv_divisor),
    .busy_o     (dv_busy),
    .quotient_o (dv_quot)
  );

  // Controller state.
  logic            pump_q, first_q, bprev_q, stop_q;
  logic [VolW-1:0] prev_q, cur_q;
  logic [AccW-1:0] racc_q, eacc_q;
  logic [AccW-1:0] ravg_q, eavg_q;

  logic            pump_d, first_d, bprev_d, stop_d;
  logic [VolW-1:0] prev_d, cur_d, vol, pv;
  logic [AccW-1:0] racc_d, eacc_d;
  logic [CntW-1:0] rcnt_d, ecnt_d;
  logic [SumW-1:0] rsum_d, esum_d;
  logic [AccW:0]   acc_sum;
  logic [SumW:0]   sum_ext;
  logic            do_start, do_stop;

  always_comb begin
    pump_d = pump_q; first_d = first_q; bprev_d = bprev_q; stop_d = 1'b0;
    prev_d = prev_q; cur_d = cur_q;
    racc_d = racc_q; eacc_d = eacc_q;
    rcnt_d = rcnt_q; ecnt_d = ecnt_q;
    rsum_d = rsum_q; esum_d = esum_q;
    vol = dv_quot[VolW-1:0];
    pv  = first_q ? vol : prev_q;
    acc_sum = '0; sum_ext = '0;
    do_start = 1'b0; do_stop = 1'b0;
    case (cmd_q)
      CmdEcho: begin
        cur_d = vol; first_d = 1'b0; prev_d = vol;
        if (pump_q) begin
          if (vol > pv && (vol - pv) > dband_q) begin
            acc_sum = {1'b0, racc_q} + (AccW+1)'(vol - pv);
            racc_d  = (acc_sum > {1'b0, AccMax}) ? AccMax : acc_sum[AccW-1:0];
          end
          if (vol >= full_q) begin
            do_stop = 1'b1; stop_d = 1'b1;
          end
        end else if (pv > vol && (pv - vol) > dband_q) begin
          acc_sum = {1'b0, eacc_q} + (AccW+1)'(pv - vol);
          eacc_d  = (acc_sum > {1'b0, AccMax}) ? AccMax : acc_sum[AccW-1:0];
        end
        if ((!pump_q || do_stop) && dist_q >= {2'b0, rdist_q}) do_start = 1'b1;
      end
      CmdButton: begin
        if (!btn_q && bprev_q) begin
          do_start = !pump_q;
          do_stop  = pump_q;
        end
        bprev_d = btn_q;
      end
      CmdRemote: begin
        do_start = rem_q;
        do_stop  = !rem_q;
      end
      default: ;
    endcase
    // Close the refill cycle on a stop.
    if (do_stop) begin
      pump_d = 1'b0;
      if (racc_d != '0) begin
        if (rcnt_q != CntMax) rcnt_d = rcnt_q + 1'b1;
        sum_ext = {1'b0, rsum_q} + (SumW+1)'(racc_d);
        rsum_d  = sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
        racc_d  = '0;
      end
    end
    // Close the evaporation cycle on a start.
    if (do_start) begin
      pump_d = 1'b1;
      if (eacc_d != '0) begin
        if (ecnt_q != CntMax) ecnt_d = ecnt_q + 1'b1;
        sum_ext = {1'b0, esum_q} + (SumW+1)'(eacc_d);
        esum_d  = sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
        eacc_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_q <= 1'b0; first_q <= 1'b1; bprev_q <= 1'b1; stop_q <= 1'b0;
      prev_q <= '0; cur_q <= '0;
      racc_q <= '0; eacc_q <= '0;
      rcnt_q <= '0; ecnt_q <= '0;
      rsum_q <= '0; esum_q <= '0;
      ravg_q <= '0; eavg_q <= '0;
    end else begin
      if (cmd_i.update) begin
        pump_q <= pump_d; first_q <= first_d; bprev_q <= bprev_d; stop_q <= stop_d;
        prev_q <= prev_d; cur_q <= cur_d;
        racc_q <= racc_d; eacc_q <= eacc_d;
        rcnt_q <= rcnt_d; ecnt_q <= ecnt_d;
        rsum_q <= rsum_d; esum_q <= esum_d;
      end
      // Averages land when the divider finishes; zero count reads as zero.
      if (cmd_i.out_load && !cmd_i.avg_sel) begin
        ravg_q <= (rcnt_q == '0) ? '0 :
                  (dv_quot > SumW'(AccMax)) ? AccMax : dv_quot[AccW-1:0];
      end
      if (cmd_i.out_load && cmd_i.avg_sel) begin
        eavg_q <= (ecnt_q == '0) ? '0 :
                  (dv_quot > SumW'(AccMax)) ? AccMax : dv_quot[AccW-1:0];
      end
    end
  end

  assign status_o.div_busy = dv_busy;
  assign status_o.is_echo  = (cmd_q == CmdEcho);

  assign pump_on_o             = pump_q;
  assign volume_milli_o        = cur_q;
  assign refill_total_o        = racc_q;
  assign evaporation_total_o   = eacc_q;
  assign refill_cycles_o       = rcnt_q;
  assign evaporation_cycles_o  = ecnt_q;
  assign refill_average_o      = ravg_q;
  assign evaporation_average_o = eavg_q;
  assign full_stop_o           = stop_q;

endmodule

### hdl/trlc_controller.sv
module trlc_controller import trlc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  trlc_status_t status_i,
  output trlc_cmd_t    cmd_o
);

  trlc_state_e state_q, state_d;
  logic        started_q, started_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
    end
  end

  // Sequencing: volume divide (echo commands only), state update, then two average divides.
  always_comb begin
    state_d     = state_q;
    started_d   = 1'b0;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = StVolDiv;
        end
      end
      StVolDiv: begin
        if (!started_q) begin
          if (status_i.is_echo) begin
            cmd_o.vol_start = 1'b1;
            started_d = 1'b1;
          end else begin
            state_d = StUpdate;
          end
        end else if (!status_i.div_busy) begin
          state_d = StUpdate;
        end else begin
          started_d = 1'b1;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d = StAvgRefill;
      end
      StAvgRefill: begin
        cmd_o.avg_sel = 1'b0;
        if (!started_q) begin
          cmd_o.avg_start = 1'b1;
          started_d = 1'b1;
        end else if (!status_i.div_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = StAvgEvap;
        end else begin
          started_d = 1'b1;
        end
      end
      StAvgEvap: begin
        cmd_o.avg_sel = 1'b1;
        if (!started_q) begin
          cmd_o.avg_start = 1'b1;
          started_d = 1'b1;
        end else if (!status_i.div_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = StOut;
        end else begin
          started_d = 1'b1;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // An accepted beat never coincides with a pending result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("input and output both open");
  // The state is only updated once per beat, after capture.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.update |=> !cmd_o.update)
    else $error("double update");
  // A capture always leads to the volume step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == StVolDiv)
    else $error("capture without sequencing");

endmodule

### hdl/tank_refill_level_controller_unit.sv
// Tank refill level controller.
// Input channel (in_valid_i/in_ready_o) carries one beat: a command with an
// echo time, a button level or a remote switch. Output channel
// (out_valid_o/out_ready_i) returns one result beat per input beat with the
// pump state, fill volume, open-cycle totals, cycle counts and averages.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); the
// user must write it only while the block is idle, which the block itself
// does not enforce. One item is handled at a time. The shared
// one-bit-per-cycle 36-bit divider computes the volume (for echoes only) and
// then the two averages in turn.
// After reset the registers hold their default values, the pump is off and
// all totals, counts and sums are zero. While the receiver stalls, the
// result beat stays valid and unchanged and no new input is taken.
module tank_refill_level_controller_unit import trlc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [15:0]         echo_time_i,
  input  logic                button_level_i,
  input  logic                remote_on_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                pump_on_o,
  output logic [VolW-1:0]     volume_milli_o,
  output logic [AccW-1:0]     refill_total_o,
  output logic [AccW-1:0]     evaporation_total_o,
  output logic [CntW-1:0]     refill_cycles_o,
  output logic [CntW-1:0]     evaporation_cycles_o,
  output logic [AccW-1:0]     refill_average_o,
  output logic [AccW-1:0]     evaporation_average_o,
  output logic                full_stop_o
);

  trlc_cmd_t    cmd;
  trlc_status_t status;

  trlc_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  trlc_datapath u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .command_i             (command_i),
    .echo_time_i           (echo_time_i),
    .button_level_i        (button_level_i),
    .remote_on_i           (remote_on_i),
    .pump_on_o             (pump_on_o),
    .volume_milli_o        (volume_milli_o),
    .refill_total_o        (refill_total_o),
    .evaporation_total_o   (evaporation_total_o),
    .refill_cycles_o       (refill_cycles_o),
    .evaporation_cycles_o  (evaporation_cycles_o),
    .refill_average_o      (refill_average_o),
    .evaporation_average_o (evaporation_average_o),
    .full_stop_o           (full_stop_o)
  );

endmodule
